// ===== src/can_servo_command_engine_defines.svh =====
// Assertion helpers for the servo command engine.
`ifndef CAN_SERVO_COMMAND_ENGINE_DEFINES_SVH
`define CAN_SERVO_COMMAND_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CSCE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CSCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/csce_pkg.sv =====
`default_nettype none

package csce_pkg;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_RX_FRAME   = 3'd1,
        OP_SET_POS    = 3'd2,
        OP_SET_BRAKE  = 3'd3,
        OP_SET_FITTED = 3'd4
    } t_op;

    localparam logic [1:0] CFG_NODE_ID    = 2'd0;
    localparam logic [1:0] CFG_BRAKE_PER  = 2'd1;
    localparam logic [1:0] CFG_POS_PER    = 2'd2;
    localparam logic [1:0] CFG_STATUS_PER = 2'd3;

    localparam int CFG_DATA_W = 16;

    localparam logic [10:0] CMD_BASE_ID    = 11'h600;
    localparam logic [10:0] STATUS_REQ_ID  = 11'h500;
    localparam logic [10:0] STATUS_RX_ID   = 11'h480;

    localparam logic [31:0] BRAKE_PAY_LO   = 32'h0030_0A22;
    localparam logic [31:0] POS_PAY_LO     = 32'h0060_0322;
    localparam logic [63:0] STATUS_REQ_PAY = 64'h0000_0000_0060_0140;

    localparam logic signed [15:0] POS_LIMIT_HI = 16'sd4500;
    localparam logic signed [15:0] POS_LIMIT_LO = -16'sd4500;

    localparam int CHK_BRAKE_SET = 9;
    localparam int CHK_BRAKE_CLR = 8;

    typedef struct packed {
        logic [2:0]         operation;
        logic [10:0]        rx_ident;
        logic [63:0]        rx_payload;
        logic signed [15:0] position_cdeg;
        logic               flag;
    } t_in_item;

    typedef struct packed {
        logic        frame_valid;
        logic [10:0] tx_ident;
        logic [63:0] tx_payload;
        logic [15:0] angle_feedback;
        logic [15:0] angle_commanded;
        logic [7:0]  current_level;
        logic [7:0]  voltage_level;
        logic [15:0] self_check_word;
        logic        brake_engaged;
        logic        brake_confirmed;
        logic        last_of_run;
    } t_out_item;

endpackage

`default_nettype wire

// ===== src/can_servo_command_engine.sv =====
// CAN servo command engine.
// Input channel (i_in_valid / o_in_stall) carries one operation per transfer:
// millisecond tick, received frame, position target, brake target or
// brake-fitted mode. Output channel (o_out_valid / i_out_stall) carries one
// result per transfer; every input item gives one to three results, the final
// one flagged with last_of_run. A tick gives brake command, position write and
// status request frames as their periods fall due; anything else gives one
// result with no frame. Status fields show the state after the item.
// The first result passes through the pending-result stage and then the output
// register before it is valid on the output.
// One result per cycle while the receiver does not stall; a new item is taken
// in the cycle in which the last result of the previous item is taken.
// The limit is the single pending-result stage that feeds the output register.
// Configuration writes (i_cfg_we) take effect at once; the user must make them only while idle (not enforced).
// Reset (i_rst_n low, synchronous) clears all state, drops pending results and
// loads the register defaults 0, 100, 5, 100.
// While the receiver stalls, the output holds and the input stalls once the
// pending stage is still occupied.
`default_nettype none
`include "can_servo_command_engine_defines.svh"

module can_servo_command_engine (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [1:0]                      i_cfg_index,
    input  wire logic [csce_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire csce_pkg::t_in_item              i_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output csce_pkg::t_out_item                  o_out
);
    import csce_pkg::*;

    // configuration
    logic [7:0]  r_node_id;
    logic [15:0] r_brake_period;
    logic [15:0] r_pos_period;
    logic [15:0] r_status_period;

    // servo state
    logic [31:0] r_time,    n_time;
    logic [31:0] r_brake_at, n_brake_at;
    logic [31:0] r_pos_at,   n_pos_at;
    logic [31:0] r_status_at, n_status_at;
    logic [15:0] r_pos_target, n_pos_target;
    logic        r_brake_target, n_brake_target;
    logic        r_brake_state, n_brake_state;
    logic        r_brake_ok, n_brake_ok;
    logic        r_brake_fitted, n_brake_fitted;
    logic [15:0] r_feedback, n_feedback;
    logic [15:0] r_rep_cmd, n_rep_cmd;
    logic [31:0] r_rep_power, n_rep_power;

    // pending results of one item: bit 0 brake, bit 1 position, bit 2 status
    logic        r_pb_valid;
    logic [2:0]  r_pb_mask, n_mask;
    logic        r_pb_brake_off;
    logic [15:0] r_pb_pos;
    logic [15:0] r_pb_feedback;
    logic [15:0] r_pb_rep_cmd;
    logic [31:0] r_pb_power;
    logic        r_pb_state;
    logic        r_pb_ok;

    logic        r_out_valid;
    t_out_item   r_out, n_out;

    logic        in_acc;
    logic        pb_take;
    logic [2:0]  pb_pick;
    logic [2:0]  pb_rest;
    logic        pb_last;

    logic [31:0] tick_time;
    logic        due_brake, due_pos, due_status;
    logic        send_brake, send_pos, pos_allowed;
    logic [10:0] status_rx_id;
    logic [10:0] cmd_id;
    logic [15:0] chk;
    logic        state_after_rx;
    logic [15:0] pos_clamped;

    assign pb_take    = r_pb_valid && (!r_out_valid || !i_out_stall);
    assign pb_pick    = r_pb_mask[0] ? 3'b001 :
                        r_pb_mask[1] ? 3'b010 :
                        r_pb_mask[2] ? 3'b100 : 3'b000;
    assign pb_rest    = r_pb_mask & ~pb_pick;
    assign pb_last    = (pb_rest == 3'b000);
    assign o_in_stall = r_pb_valid && !(pb_take && pb_last);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign tick_time   = r_time + 32'd1;
    assign due_brake   = (tick_time - r_brake_at)  > {16'd0, r_brake_period};
    assign due_pos     = (tick_time - r_pos_at)    > {16'd0, r_pos_period};
    assign due_status  = (tick_time - r_status_at) > {16'd0, r_status_period};
    assign pos_allowed = r_brake_fitted ? (!r_brake_ok || !r_brake_state) : 1'b1;
    assign send_brake  = !r_brake_ok && due_brake;
    assign send_pos    = pos_allowed && due_pos;

    assign status_rx_id = STATUS_RX_ID + {3'd0, r_node_id};
    assign cmd_id       = CMD_BASE_ID + {3'd0, r_node_id};
    assign chk          = i_in.rx_payload[63:48];
    // clear bit overrides set bit
    assign state_after_rx = chk[CHK_BRAKE_CLR] ? 1'b0 :
                            chk[CHK_BRAKE_SET] ? 1'b1 : r_brake_state;
    assign pos_clamped  = (i_in.position_cdeg > POS_LIMIT_HI) ? POS_LIMIT_HI :
                          (i_in.position_cdeg < POS_LIMIT_LO) ? POS_LIMIT_LO :
                          i_in.position_cdeg;

    always_comb begin
        n_time         = r_time;
        n_brake_at     = r_brake_at;
        n_pos_at       = r_pos_at;
        n_status_at    = r_status_at;
        n_pos_target   = r_pos_target;
        n_brake_target = r_brake_target;
        n_brake_state  = r_brake_state;
        n_brake_ok     = r_brake_ok;
        n_brake_fitted = r_brake_fitted;
        n_feedback     = r_feedback;
        n_rep_cmd      = r_rep_cmd;
        n_rep_power    = r_rep_power;
        n_mask         = 3'b000;
        case (t_op'(i_in.operation))
            OP_TICK: begin
                n_time = tick_time;
                n_mask = {due_status, send_pos, send_brake};
                if (send_brake) begin
                    n_brake_at = tick_time;
                end
                if (send_pos) begin
                    n_pos_at = tick_time;
                end
                if (due_status) begin
                    n_status_at = tick_time;
                end
            end
            OP_RX_FRAME: begin
                if (i_in.rx_ident == status_rx_id) begin
                    n_feedback    = i_in.rx_payload[15:0];
                    n_rep_cmd     = i_in.rx_payload[31:16];
                    n_rep_power   = {chk, i_in.rx_payload[47:32]};
                    n_brake_state = state_after_rx;
                    if (r_brake_target == state_after_rx) begin
                        n_brake_ok = 1'b1;
                    end
                end
            end
            OP_SET_POS: begin
                n_pos_target = pos_clamped;
            end
            OP_SET_BRAKE: begin
                n_brake_target = i_in.flag;
                n_brake_ok     = 1'b0;
            end
            OP_SET_FITTED: begin
                n_brake_fitted = i_in.flag;
                if (!i_in.flag && (!r_brake_ok || r_brake_target)) begin
                    n_brake_target = 1'b0;
                    n_brake_ok     = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out.frame_valid     = (r_pb_mask != 3'b000);
        n_out.tx_ident        = 11'd0;
        n_out.tx_payload      = 64'd0;
        n_out.angle_feedback  = r_pb_feedback;
        n_out.angle_commanded = r_pb_rep_cmd;
        n_out.current_level   = r_pb_power[7:0];
        n_out.voltage_level   = r_pb_power[15:8];
        n_out.self_check_word = r_pb_power[31:16];
        n_out.brake_engaged   = r_pb_state;
        n_out.brake_confirmed = r_pb_ok;
        n_out.last_of_run     = pb_last;
        case (pb_pick)
            3'b001: begin
                n_out.tx_ident   = cmd_id;
                n_out.tx_payload = {24'd0, 7'd0, r_pb_brake_off, BRAKE_PAY_LO};
            end
            3'b010: begin
                n_out.tx_ident   = cmd_id;
                n_out.tx_payload = {16'd0, r_pb_pos, POS_PAY_LO};
            end
            3'b100: begin
                n_out.tx_ident   = STATUS_REQ_ID + {3'd0, r_node_id};
                n_out.tx_payload = STATUS_REQ_PAY;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id       <= 8'd0;
            r_brake_period  <= 16'd100;
            r_pos_period    <= 16'd5;
            r_status_period <= 16'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NODE_ID:    r_node_id       <= i_cfg_data[7:0];
                CFG_BRAKE_PER:  r_brake_period  <= i_cfg_data[15:0];
                CFG_POS_PER:    r_pos_period    <= i_cfg_data[15:0];
                CFG_STATUS_PER: r_status_period <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time         <= 32'd0;
            r_brake_at     <= 32'd0;
            r_pos_at       <= 32'd0;
            r_status_at    <= 32'd0;
            r_pos_target   <= 16'd0;
            r_brake_target <= 1'b0;
            r_brake_state  <= 1'b0;
            r_brake_ok     <= 1'b0;
            r_brake_fitted <= 1'b0;
            r_feedback     <= 16'd0;
            r_rep_cmd      <= 16'd0;
            r_rep_power    <= 32'd0;
        end else if (in_acc) begin
            r_time         <= n_time;
            r_brake_at     <= n_brake_at;
            r_pos_at       <= n_pos_at;
            r_status_at    <= n_status_at;
            r_pos_target   <= n_pos_target;
            r_brake_target <= n_brake_target;
            r_brake_state  <= n_brake_state;
            r_brake_ok     <= n_brake_ok;
            r_brake_fitted <= n_brake_fitted;
            r_feedback     <= n_feedback;
            r_rep_cmd      <= n_rep_cmd;
            r_rep_power    <= n_rep_power;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pb_valid  <= 1'b0;
            r_pb_mask   <= 3'b000;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_pb_valid <= 1'b1;
                r_pb_mask  <= n_mask;
            end else if (pb_take) begin
                r_pb_mask <= pb_rest;
                if (pb_last) begin
                    r_pb_valid <= 1'b0;
                end
            end
            if (pb_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: frame contents and status snapshot of the item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pb_brake_off <= !r_brake_target;
            r_pb_pos       <= r_pos_target;
            r_pb_feedback  <= n_feedback;
            r_pb_rep_cmd   <= n_rep_cmd;
            r_pb_power     <= n_rep_power;
            r_pb_state     <= n_brake_state;
            r_pb_ok        <= n_brake_ok;
        end
        if (pb_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `CSCE_ASSERT_NEXT(a_accept_fills_pending, in_acc, r_pb_valid,
        "accepted item left no pending results")
    `CSCE_ASSERT_NEXT(a_time_only_on_transfer, !in_acc, $stable(r_time),
        "millisecond counter moved without an input transfer")
    `CSCE_ASSERT_NOW(a_empty_result_is_last, o_out_valid && !o_out.frame_valid,
        o_out.last_of_run && o_out.tx_ident == 11'd0 && o_out.tx_payload == 64'd0,
        "frameless result not last or not blank")

endmodule

`default_nettype wire
